[rtl/sha1_pkg.sv]
// ---------------------------------------------------------------------------
// SHA-1 hasher package
// Shared item type, round constants and helper functions of the SHA-1 hasher.
// ---------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

  // One classified input item as it travels from the front end to the engine.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } item_t;

  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int ROUNDS = 80;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  function automatic logic [31:0] rol1(input logic [31:0] v);
    rol1 = {v[30:0], v[31]};
  endfunction

  function automatic logic [31:0] rol5(input logic [31:0] v);
    rol5 = {v[26:0], v[31:27]};
  endfunction

  function automatic logic [31:0] rol30(input logic [31:0] v);
    rol30 = {v[1:0], v[31:2]};
  endfunction

endpackage

`default_nettype wire

[rtl/sha1_queue.sv]
// ---------------------------------------------------------------------------
// SHA-1 item queue
// Small first-in first-out queue of classified items between front and engine.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1_queue
  import sha1_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output item_t      pop_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sha1_front.sv]
// ---------------------------------------------------------------------------
// SHA-1 front end
// Registers input items, drops items that carry neither byte nor end mark.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1_front
  import sha1_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       byte_valid,
  input  wire logic       end_of_message,
  output logic            push_valid,
  input  wire logic       push_ready,
  output item_t           push_item
);

  logic  st_valid;
  item_t st_item;
  logic  take;

  assign in_ready   = !st_valid || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = st_valid;
  assign push_item  = st_item;

  always_ff @(posedge clk) begin
    if (take) begin
      st_item.data     <= data_byte;
      st_item.has_byte <= byte_valid;
      st_item.last     <= end_of_message;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (take) begin
      // An item with no byte and no end mark has no effect at all.
      st_valid <= byte_valid || end_of_message;
    end else if (push_ready) begin
      st_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/sha1_back.sv]
// ---------------------------------------------------------------------------
// SHA-1 back end
// Packs bytes into blocks, generates padding, runs the rounds, emits digests.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1_back
  import sha1_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   pop_valid,
  output logic        pop_ready,
  input  wire item_t  pop_item,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_done
);

  localparam logic [1:0] C_MSG  = 2'd0;
  localparam logic [1:0] C_MARK = 2'd1;
  localparam logic [1:0] C_WRAP = 2'd2;
  localparam logic [1:0] C_TAIL = 2'd3;

  localparam logic [1:0] E_IDLE  = 2'd0;
  localparam logic [1:0] E_ROUND = 2'd1;
  localparam logic [1:0] E_FIN   = 2'd2;
  localparam logic [1:0] E_OUT   = 2'd3;

  // Collector state.
  logic [1:0]  mode;
  logic [1:0]  mode_next;
  logic [5:0]  pos;
  logic [23:0] partial;
  logic [63:0] bit_length;
  logic [31:0] block_words [16];
  logic        buf_full;
  logic        buf_final;
  logic        ins_en;
  logic [7:0]  ins_byte;
  logic        len_add;
  logic [7:0]  len_byte;

  // Engine state.
  logic [1:0]  estate;
  logic [6:0]  rnd;
  logic [31:0] sched [16];
  logic [31:0] cv [5];
  logic [31:0] ra, rb, rc, rd, re;
  logic        blk_final;
  logic [2:0]  oidx;
  logic        load;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;
  logic [31:0] w_new;
  logic [31:0] cv_sel;

  assign len_byte = bit_length[{~pos[2:0], 3'b000} +: 8];
  assign load     = (estate == E_IDLE) && buf_full;

  always_comb begin
    ins_en    = 1'b0;
    ins_byte  = '0;
    len_add   = 1'b0;
    pop_ready = 1'b0;
    mode_next = mode;
    if (!buf_full) begin
      case (mode)
        C_MSG: begin
          if (pop_valid) begin
            pop_ready = 1'b1;
            if (pop_item.has_byte) begin
              ins_en   = 1'b1;
              ins_byte = pop_item.data;
              len_add  = 1'b1;
            end
            if (pop_item.last) begin
              mode_next = C_MARK;
            end
          end
        end
        C_MARK: begin
          ins_en   = 1'b1;
          ins_byte = PAD_MARK;
          // When the marker lands inside the length field the block is
          // zero-filled and the length moves into a block of its own.
          if (pos[5:3] == 3'd7 && pos != 6'd63) begin
            mode_next = C_WRAP;
          end else begin
            mode_next = C_TAIL;
          end
        end
        C_WRAP: begin
          ins_en = 1'b1;
          if (pos == 6'd63) begin
            mode_next = C_TAIL;
          end
        end
        C_TAIL: begin
          ins_en   = 1'b1;
          ins_byte = (pos[5:3] == 3'd7) ? len_byte : 8'd0;
          if (pos == 6'd63) begin
            mode_next = C_MSG;
          end
        end
        default: begin
          mode_next = C_MSG;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ins_en) begin
      if (pos[1:0] == 2'd3) begin
        block_words[pos[5:2]] <= {partial, ins_byte};
      end else begin
        partial <= {partial[15:0], ins_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= C_MSG;
      pos        <= '0;
      bit_length <= '0;
      buf_full   <= 1'b0;
      buf_final  <= 1'b0;
    end else begin
      mode <= mode_next;
      if (ins_en) begin
        pos <= pos + 1'b1;
        if (pos == 6'd63) begin
          buf_full  <= 1'b1;
          buf_final <= (mode == C_TAIL);
        end
      end else if (load) begin
        buf_full <= 1'b0;
      end
      if (len_add) begin
        bit_length <= bit_length + 64'd8;
      end else if (ins_en && mode == C_TAIL && pos == 6'd63) begin
        bit_length <= '0;
      end
    end
  end

  always_comb begin
    if (rnd < 7'd20) begin
      f_val = (rb & rc) | (~rb & rd);
      k_val = K0;
    end else if (rnd < 7'd40) begin
      f_val = rb ^ rc ^ rd;
      k_val = K1;
    end else if (rnd < 7'd60) begin
      f_val = (rb & rc) | (rb & rd) | (rc & rd);
      k_val = K2;
    end else begin
      f_val = rb ^ rc ^ rd;
      k_val = K3;
    end
    t_val = rol5(ra) + f_val + re + k_val + sched[0];
    w_new = rol1(sched[13] ^ sched[8] ^ sched[2] ^ sched[0]);
  end

  always_comb begin
    case (oidx)
      3'd0:    cv_sel = cv[0];
      3'd1:    cv_sel = cv[1];
      3'd2:    cv_sel = cv[2];
      3'd3:    cv_sel = cv[3];
      3'd4:    cv_sel = cv[4];
      default: cv_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    case (estate)
      E_IDLE: begin
        if (load) begin
          for (int i = 0; i < 16; i++) begin
            sched[i] <= block_words[i];
          end
          ra        <= cv[0];
          rb        <= cv[1];
          rc        <= cv[2];
          rd        <= cv[3];
          re        <= cv[4];
          blk_final <= buf_final;
        end
      end
      E_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          sched[i] <= sched[i + 1];
        end
        sched[15] <= w_new;
        ra        <= t_val;
        rb        <= ra;
        rc        <= rol30(rb);
        rd        <= rc;
        re        <= rd;
      end
      default: begin
      end
    endcase
    if (estate == E_OUT && !out_valid) begin
      digest_word <= cv_sel;
      word_index  <= oidx;
      digest_done <= (oidx == 3'd4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      estate    <= E_IDLE;
      rnd       <= '0;
      oidx      <= '0;
      out_valid <= 1'b0;
      cv[0]     <= H0_INIT;
      cv[1]     <= H1_INIT;
      cv[2]     <= H2_INIT;
      cv[3]     <= H3_INIT;
      cv[4]     <= H4_INIT;
    end else begin
      case (estate)
        E_IDLE: begin
          if (load) begin
            rnd    <= '0;
            estate <= E_ROUND;
          end
        end
        E_ROUND: begin
          rnd <= rnd + 1'b1;
          if (rnd == 7'(ROUNDS - 1)) begin
            estate <= E_FIN;
          end
        end
        E_FIN: begin
          cv[0]  <= cv[0] + ra;
          cv[1]  <= cv[1] + rb;
          cv[2]  <= cv[2] + rc;
          cv[3]  <= cv[3] + rd;
          cv[4]  <= cv[4] + re;
          oidx   <= '0;
          estate <= blk_final ? E_OUT : E_IDLE;
        end
        E_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            oidx      <= oidx + 1'b1;
            if (oidx == 3'd4) begin
              cv[0]  <= H0_INIT;
              cv[1]  <= H1_INIT;
              cv[2]  <= H2_INIT;
              cv[3]  <= H3_INIT;
              cv[4]  <= H4_INIT;
              estate <= E_IDLE;
            end
          end
        end
        default: begin
          estate <= E_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/sha1_message_hasher_top.sv]
// ---------------------------------------------------------------------------
// SHA-1 message hasher, top level
// Byte-serial SHA-1: front stage, item queue and a block/round engine.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle into the block buffer while it is not full;
//   a full block is compressed in steps (load, 80 rounds, chaining add) by
//   the one-round-per-cycle loop, while the next block is being collected.
// End of message: the end item adds 9 to 72 padding bytes, one or two block
//   compressions, then each digest word is shown from an output register.
// Reset: synchronous; clears handshake and queue state and loads the initial
//   chaining values. The block buffer needs no clearing pass.
`default_nettype none

module sha1_message_hasher_top
  import sha1_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_valid,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             digest_done
);

  // The front stage registers each item and drops the ones that carry
  // neither a byte nor an end mark, since those change nothing.
  logic  push_valid;
  logic  push_ready;
  item_t push_item;

  // Items popped by the back end, which may stall on a full block buffer
  // or during padding while the front keeps filling the queue.
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  sha1_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  sha1_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // The back end collects bytes of the next block while the rounds of the
  // previous block run, and holds each digest word in an output register.
  sha1_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .digest_done (digest_done)
  );

endmodule

`default_nettype wire
